FILE: sv/blt_pkg.sv
// ----------------------------------------------------------------------------
// blt_pkg
// shared types and constants of the bracketed list tokenizer
// ----------------------------------------------------------------------------
package blt_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned CountWidth = 16;

  // saturation limit of the element counter
  localparam logic [CountWidth-1:0] MAX_ELEMENTS = 16'd65535;

  localparam logic [CharWidth-1:0] OPEN_CHAR_RESET  = 8'd123;
  localparam logic [CharWidth-1:0] CLOSE_CHAR_RESET = 8'd125;
  localparam logic [CharWidth-1:0] BACKSLASH        = 8'h5C;

  // escape letters and the control codes they stand for
  localparam logic [CharWidth-1:0] CHAR_N   = 8'h6E;
  localparam logic [CharWidth-1:0] CHAR_T   = 8'h74;
  localparam logic [CharWidth-1:0] CHAR_R   = 8'h72;
  localparam logic [CharWidth-1:0] CHAR_V   = 8'h76;
  localparam logic [CharWidth-1:0] CODE_LF  = 8'h0A;
  localparam logic [CharWidth-1:0] CODE_TAB = 8'h09;
  localparam logic [CharWidth-1:0] CODE_CR  = 8'h0D;
  localparam logic [CharWidth-1:0] CODE_VT  = 8'h0B;

  // apb register map, index taken from paddr[2]
  localparam logic REG_OPEN_CHAR  = 1'b0;
  localparam logic REG_CLOSE_CHAR = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_END   = 2'd2
  } blt_kind_e;

  typedef struct packed {
    logic                  in_element;
    logic                  escape_pending;
    logic                  error_seen;
    logic [CountWidth-1:0] element_counter;
  } blt_state_t;

  typedef struct packed {
    blt_kind_e             kind;
    logic [CharWidth-1:0]  char_out;
    logic                  inside_element;
    logic [CountWidth-1:0] element_index;
    logic                  bad_value;
    logic [CountWidth-1:0] element_count;
  } blt_result_t;

endpackage

FILE: sv/blt_step.sv
// ----------------------------------------------------------------------------
// blt_step
// per-character state update and result generation of the tokenizer
// ----------------------------------------------------------------------------
module blt_step #(
  parameter logic [blt_pkg::CountWidth-1:0] MaxElements = blt_pkg::MAX_ELEMENTS
) (
  input  blt_pkg::blt_state_t            state_i,
  input  logic [blt_pkg::CharWidth-1:0]  char_i,
  input  logic                           end_of_string_i,
  input  logic [blt_pkg::CharWidth-1:0]  open_char_i,
  input  logic [blt_pkg::CharWidth-1:0]  close_char_i,
  output blt_pkg::blt_state_t            state_o,
  output logic                           has_result_o,
  output blt_pkg::blt_result_t           result_o
);
  import blt_pkg::*;

  function automatic logic [CharWidth-1:0] decode_escape(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] r;
    case (c)
      CHAR_N:  r = CODE_LF;
      CHAR_T:  r = CODE_TAB;
      CHAR_R:  r = CODE_CR;
      CHAR_V:  r = CODE_VT;
      default: r = c;
    endcase
    return r;
  endfunction

  logic [CountWidth-1:0] cur_index;

  assign cur_index = (state_i.element_counter == '0) ? '0
                   : state_i.element_counter - CountWidth'(1);

  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    result_o     = '{kind: KIND_DATA, char_out: char_i, inside_element: state_i.in_element,
                     element_index: cur_index, bad_value: 1'b0, element_count: '0};
    if (end_of_string_i) begin
      has_result_o           = 1'b1;
      result_o.kind          = KIND_END;
      result_o.char_out      = '0;
      result_o.inside_element = 1'b0;
      result_o.element_index = '0;
      result_o.bad_value     = state_i.error_seen | state_i.in_element;
      result_o.element_count = state_i.element_counter;
      state_o                = '0;
    end else if (state_i.escape_pending) begin
      state_o.escape_pending = 1'b0;
      has_result_o           = 1'b1;
      result_o.char_out      = decode_escape(char_i);
    end else if (char_i == open_char_i && !state_i.in_element) begin
      state_o.in_element = 1'b1;
      if (state_i.element_counter < MaxElements) begin
        state_o.element_counter = state_i.element_counter + CountWidth'(1);
      end
    end else if (char_i == close_char_i) begin
      if (state_i.in_element) begin
        state_o.in_element      = 1'b0;
        has_result_o            = 1'b1;
        result_o.kind           = KIND_CLOSE;
        result_o.char_out       = '0;
        result_o.inside_element = 1'b0;
      end else begin
        state_o.error_seen = 1'b1;
      end
    end else if (char_i == BACKSLASH) begin
      state_o.escape_pending = 1'b1;
    end else begin
      has_result_o = 1'b1;
    end
  end

endmodule

FILE: sv/bracketed_list_tokenizer_core.sv
// ----------------------------------------------------------------------------
// bracketed_list_tokenizer_core
// streaming splitter of a delimited list string, one character per beat
// ----------------------------------------------------------------------------
// Takes one character per input beat and an end beat (tlast high) that closes
// the string. The block sustains one beat per cycle in both directions while
// the output is not stalled; a taken input beat passes the input register,
// then the result register, before its result is on the output. A beat that
// yields no result (delimiter, backslash, unmatched close) is consumed
// silently. The single-pass flag and counter update between the two
// registers sets the rate. Each output beat carries its kind in tuser:
// data character, element closed or end status. On end status bad_value flags
// mismatched delimiters (an unclosed element counts) and element_count gives
// the number of opened elements, saturating at MaxElements; all tokenizer
// state then clears. Delimiter codes live in two apb registers (open at 0x0,
// close at 0x4) and may only be rewritten while the block idles.
module bracketed_list_tokenizer_core #(
  parameter logic [blt_pkg::CountWidth-1:0] MaxElements = blt_pkg::MAX_ELEMENTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // end_of_string
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] char_out, [8] inside_element, [24:9] element_index, [25] bad_value,
  // [41:26] element_count, [47:42] zero
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import blt_pkg::*;

  // delimiter registers
  logic [CharWidth-1:0] open_char_q, close_char_q;
  logic                 cfg_write;

  // input stage
  logic                 in_valid_q, in_valid_d;
  logic [CharWidth-1:0] in_char_q;
  logic                 in_eos_q;

  // tokenizer state
  blt_state_t           state_q, state_d;

  // result stage
  logic                 out_valid_q, out_valid_d;
  blt_result_t          out_q, result;
  logic                 has_result;

  logic                 advance;   // result register can take a new value
  logic                 consume;   // input stage item is processed this cycle
  logic                 in_accept;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_OPEN_CHAR:  prdata[CharWidth-1:0] = open_char_q;
      REG_CLOSE_CHAR: prdata[CharWidth-1:0] = close_char_q;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_char_q  <= OPEN_CHAR_RESET;
      close_char_q <= CLOSE_CHAR_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_OPEN_CHAR) begin
        open_char_q <= pwdata[CharWidth-1:0];
      end else begin
        close_char_q <= pwdata[CharWidth-1:0];
      end
    end
  end

  // handshake: the input stage frees up whenever its item moves on, so a
  // held result does not stop the next beat unless the result is stalled
  assign advance       = ~out_valid_q | m_axis_tready;
  assign consume       = in_valid_q & advance;
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  assign in_valid_d  = in_accept | (in_valid_q & ~consume);
  assign out_valid_d = advance ? (consume & has_result) : out_valid_q;

  blt_step #(
    .MaxElements (MaxElements)
  ) u_step (
    .state_i         (state_q),
    .char_i          (in_char_q),
    .end_of_string_i (in_eos_q),
    .open_char_i     (open_char_q),
    .close_char_i    (close_char_q),
    .state_o         (state_d),
    .has_result_o    (has_result),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (consume) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_char_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
    if (consume) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'b0, out_q.element_count, out_q.bad_value, out_q.element_index,
                          out_q.inside_element, out_q.char_out};

endmodule

FILE: sv/bracketed_list_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// bracketed_list_tokenizer_checker
// port-level properties of the tokenizer core, bound to the top level
// ----------------------------------------------------------------------------
module bracketed_list_tokenizer_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import blt_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // an empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // only the three defined kinds appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_CLOSE
                       || m_axis_tuser == KIND_END))
    else $error("undefined result kind");

  // non-data beats carry no character and no inside flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[8:0] == 9'd0)
    else $error("non-data beat with character bits");

  // status fields only on end beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_END |-> m_axis_tdata[47:25] == 23'd0)
    else $error("status fields set outside end beat");

endmodule

bind bracketed_list_tokenizer_core bracketed_list_tokenizer_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
